// ===== sv/irr_pkg.sv =====
// irr_pkg: shared types and constants for the inscribed rotated rectangle block
// used by irr_trig, irr_div and inscribed_rotated_rectangle_top; no dependencies
package irr_pkg;

  localparam int          LEN_W    = 32;          // Q16.16 lengths
  localparam int          TRIG_W   = 31;          // unsigned Q30 c and s, up to 1.0
  localparam int          NUM_W    = 33;          // divider numerator
  localparam int          DEN_W    = 32;          // divider denominator
  localparam int          QUO_W    = 36;          // divider quotient; overflow is flagged
  localparam int          PRE_SH   = QUO_W - 30;  // quotient bits above the q30 point

  localparam logic [30:0] ONE_T    = 31'd1073741824;
  localparam logic [31:0] PI_Q30   = 32'd3373259426;
  localparam logic [30:0] DIAG_TOL = 31'd1074;

  typedef enum logic [2:0] {
    CASE_EMPTY  = 3'd0,
    CASE_WIDTH  = 3'd1,
    CASE_HEIGHT = 3'd2,
    CASE_DIAG   = 3'd3,
    CASE_BOTH   = 3'd4
  } solve_case_e;

  typedef struct packed {
    logic [LEN_W-1:0] p;
    logic [LEN_W-1:0] q;
  } box_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } lane_in_t;

  typedef struct packed {
    logic [QUO_W-1:0] quo;
    logic             ovf;
    logic             dz;
  } lane_out_t;

  typedef struct packed {
    solve_case_e      kase;
    logic [LEN_W-1:0] lim;
    logic             neg;
  } div_side_t;

endpackage

// ===== sv/irr_trig.sv =====
// irr_trig: pipelined |cos| and |sin| of a binary angle as Taylor series in Q30
// depends on irr_pkg; one series term per three stages, one request per cycle while the output is not stalled
module irr_trig import irr_pkg::*; #(
  parameter int TRIG_STEPS = 18
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [15:0]         angle_i,
  input  box_t                box_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [TRIG_W-1:0]   cos_o,
  output logic [TRIG_W-1:0]   sin_o,
  output box_t                box_o
);

  localparam int NSTEP = TRIG_STEPS - 1;
  localparam int NS    = 3 + 3 * NSTEP;
  localparam logic [15:0] ANG_QUARTER = 16'h4000;
  localparam logic [15:0] ANG_HALF    = 16'h8000;

  typedef struct packed {
    logic [30:0]        x;
    logic [31:0]        x2;
    logic [31:0]        ct;
    logic [31:0]        st;
    logic [32:0]        nc;
    logic [32:0]        ns;
    logic [31:0]        qc;
    logic [31:0]        qs;
    logic signed [33:0] ca;
    logic signed [33:0] sa;
    logic [30:0]        cc;
    logic [30:0]        sc;
    box_t               box;
  } trig_t;

  trig_t          st_q [NS];
  trig_t          st_d [NS];
  logic [NS-1:0]  v_q;
  logic [NS-1:0]  vin;
  logic [NS:0]    en;

  assign en[NS] = ready_i;
  assign vin    = {v_q[NS-2:0], valid_i};

  for (genvar i = 0; i < NS; i++) begin : g_stage
    assign en[i] = ~v_q[i] | en[i+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en[i]) begin
        v_q[i] <= vin[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[i]) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  // fold into the first quadrant, then to radians
  always_comb begin
    logic [15:0] a16;
    logic [46:0] xm;
    a16 = {1'b0, angle_i[14:0]};
    if (a16 > ANG_QUARTER) begin
      a16 = ANG_HALF - a16;
    end
    xm = 47'(a16[14:0]) * 47'(PI_Q30) + 47'd16384;
    st_d[0]     = '0;
    st_d[0].x   = xm[45:15];
    st_d[0].box = box_i;
  end

  always_comb begin
    logic [61:0] sq;
    sq = 62'(st_q[0].x) * 62'(st_q[0].x) + 62'd536870912;
    st_d[1]    = st_q[0];
    st_d[1].x2 = sq[61:30];
    st_d[1].ct = 32'(ONE_T);
    st_d[1].st = 32'(st_q[0].x);
    st_d[1].ca = 34'(ONE_T);
    st_d[1].sa = 34'(st_q[0].x);
  end

  for (genvar j = 0; j < NSTEP; j++) begin : g_term
    localparam int K  = j + 1;
    localparam int DC = (2 * K - 1) * (2 * K);
    localparam int DS = (2 * K) * (2 * K + 1);
    localparam logic [32:0] MC = 33'((64'd1 << 33) / DC);
    localparam logic [32:0] MS = 33'((64'd1 << 33) / DS);
    localparam int B  = 2 + 3 * j;

    // term times x^2
    always_comb begin
      logic [63:0] mc;
      logic [63:0] ms;
      mc = 64'(st_q[B-1].ct) * 64'(st_q[B-1].x2);
      ms = 64'(st_q[B-1].st) * 64'(st_q[B-1].x2);
      st_d[B]    = st_q[B-1];
      st_d[B].nc = mc[62:30];
      st_d[B].ns = ms[62:30];
    end

    // reciprocal estimate, low by at most one
    always_comb begin
      logic [65:0] pc;
      logic [65:0] ps;
      pc = 66'(st_q[B].nc) * 66'(MC);
      ps = 66'(st_q[B].ns) * 66'(MS);
      st_d[B+1]    = st_q[B];
      st_d[B+1].qc = pc[64:33];
      st_d[B+1].qs = ps[64:33];
    end

    // correct the quotient and accumulate with alternating sign
    always_comb begin
      logic [44:0] rc;
      logic [44:0] rs;
      logic [31:0] tc;
      logic [31:0] ts;
      rc = 45'(st_q[B+1].nc) - 45'(st_q[B+1].qc) * 45'(DC);
      rs = 45'(st_q[B+1].ns) - 45'(st_q[B+1].qs) * 45'(DS);
      tc = st_q[B+1].qc + 32'(rc >= 45'(DC));
      ts = st_q[B+1].qs + 32'(rs >= 45'(DS));
      st_d[B+2]    = st_q[B+1];
      st_d[B+2].ct = tc;
      st_d[B+2].st = ts;
      if (K % 2 == 1) begin
        st_d[B+2].ca = st_q[B+1].ca - $signed({2'b00, tc});
        st_d[B+2].sa = st_q[B+1].sa - $signed({2'b00, ts});
      end else begin
        st_d[B+2].ca = st_q[B+1].ca + $signed({2'b00, tc});
        st_d[B+2].sa = st_q[B+1].sa + $signed({2'b00, ts});
      end
    end
  end

  always_comb begin
    st_d[NS-1] = st_q[NS-2];
    if (st_q[NS-2].ca < 0) begin
      st_d[NS-1].cc = '0;
    end else if (st_q[NS-2].ca > $signed(34'(ONE_T))) begin
      st_d[NS-1].cc = ONE_T;
    end else begin
      st_d[NS-1].cc = st_q[NS-2].ca[30:0];
    end
    if (st_q[NS-2].sa < 0) begin
      st_d[NS-1].sc = '0;
    end else if (st_q[NS-2].sa > $signed(34'(ONE_T))) begin
      st_d[NS-1].sc = ONE_T;
    end else begin
      st_d[NS-1].sc = st_q[NS-2].sa[30:0];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];
  assign cos_o   = st_q[NS-1].cc;
  assign sin_o   = st_q[NS-1].sc;
  assign box_o   = st_q[NS-1].box;

endmodule

// ===== sv/irr_div.sv =====
// irr_div: two-lane pipelined restoring divider, (num * 2^30) / den, one bit per stage
// depends on irr_pkg; quotient overflow and zero divisor are flagged
module irr_div import irr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  lane_in_t [1:0]    lane_i,
  input  div_side_t         side_i,
  output logic              valid_o,
  input  logic              ready_i,
  output lane_out_t [1:0]   lane_o,
  output div_side_t         side_o
);

  localparam int NS = QUO_W + 1;

  typedef struct packed {
    logic [DEN_W-1:0]  r;
    logic [DEN_W-1:0]  den;
    logic [PRE_SH-1:0] nlo;
    logic [QUO_W-1:0]  quo;
    logic              ovf;
    logic              dz;
  } dl_t;

  typedef struct packed {
    dl_t [1:0]  ln;
    div_side_t  side;
  } ds_t;

  ds_t            st_q [NS];
  ds_t            st_d [NS];
  logic [NS-1:0]  v_q;
  logic [NS-1:0]  vin;
  logic [NS:0]    en;

  assign en[NS] = ready_i;
  assign vin    = {v_q[NS-2:0], valid_i};

  for (genvar i = 0; i < NS; i++) begin : g_stage
    assign en[i] = ~v_q[i] | en[i+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en[i]) begin
        v_q[i] <= vin[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[i]) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  // quotient fits QUO_W bits unless num >= den * 2^PRE_SH
  always_comb begin
    st_d[0].side = side_i;
    for (int l = 0; l < 2; l++) begin
      st_d[0].ln[l].den = lane_i[l].den;
      st_d[0].ln[l].dz  = (lane_i[l].den == '0);
      st_d[0].ln[l].ovf = ({(DEN_W + PRE_SH - NUM_W)'(0), lane_i[l].num}
                           >= {lane_i[l].den, PRE_SH'(0)});
      st_d[0].ln[l].r   = DEN_W'(lane_i[l].num[NUM_W-1:PRE_SH]);
      st_d[0].ln[l].nlo = lane_i[l].num[PRE_SH-1:0];
      st_d[0].ln[l].quo = '0;
    end
  end

  for (genvar g = 1; g < NS; g++) begin : g_bit
    localparam int BI = QUO_W - g;
    always_comb begin
      logic [DEN_W:0] rs;
      logic           nb;
      st_d[g] = st_q[g-1];
      for (int l = 0; l < 2; l++) begin
        if (BI >= 30) begin
          nb = st_q[g-1].ln[l].nlo[(BI >= 30) ? BI - 30 : 0];
        end else begin
          nb = 1'b0;
        end
        rs = {st_q[g-1].ln[l].r, nb};
        if (rs >= {1'b0, st_q[g-1].ln[l].den}) begin
          st_d[g].ln[l].r   = DEN_W'(rs - {1'b0, st_q[g-1].ln[l].den});
          st_d[g].ln[l].quo = {st_q[g-1].ln[l].quo[QUO_W-2:0], 1'b1};
        end else begin
          st_d[g].ln[l].r   = rs[DEN_W-1:0];
          st_d[g].ln[l].quo = {st_q[g-1].ln[l].quo[QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];
  assign side_o  = st_q[NS-1].side;

  for (genvar l = 0; l < 2; l++) begin : g_out
    assign lane_o[l].quo = st_q[NS-1].ln[l].quo;
    assign lane_o[l].ovf = st_q[NS-1].ln[l].ovf;
    assign lane_o[l].dz  = st_q[NS-1].ln[l].dz;
  end

endmodule

// ===== sv/inscribed_rotated_rectangle_top.sv =====
// inscribed_rotated_rectangle_top: largest rectangle at a turn that fits an axis-aligned box
// depends on irr_pkg, irr_trig and irr_div
//
// Each request carries half width p, half height q (unsigned Q16.16) and a 16-bit binary
// angle; the block answers with the semi-axes of the largest rectangle at that turn that fits
// the box, plus which constraint case applied. The block is a fully pipelined datapath with
// no state between requests: a new request is taken every cycle while the output is not
// stalled, and each one passes through the sine/cosine series at three stages per term and
// the 37-stage divider. A stalled output only backs up the stages that hold data, so the
// input keeps accepting while bubbles remain in the pipeline.
module inscribed_rotated_rectangle_top import irr_pkg::*; #(
  parameter int TRIG_STEPS = 18
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // half_width[31:0], half_height[63:32], turn_angle[79:64]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // semi_u[31:0], semi_v[63:32], solve_case[66:64]
);

  typedef struct packed {
    box_t              box;
    logic [TRIG_W-1:0] c;
    logic [TRIG_W-1:0] s;
    logic [31:0]       k;
    logic [63:0]       qk;
    logic [63:0]       pk;
  } geo_t;

  typedef struct packed {
    lane_in_t [1:0] ln;
    div_side_t      side;
  } sel_t;

  typedef struct packed {
    logic [LEN_W-1:0] u;
    logic [LEN_W-1:0] v;
    solve_case_e      kase;
  } res_t;

  box_t              in_box;
  logic              tr_valid;
  logic              tr_ready;
  logic [TRIG_W-1:0] tr_cos;
  logic [TRIG_W-1:0] tr_sin;
  box_t              tr_box;

  geo_t g1_q, g1_d, g2_q, g2_d;
  sel_t s3_q, s3_d;
  res_t out_q, out_d;
  logic g1_v_q, g2_v_q, s3_v_q, out_v_q;
  logic en1, en2, en3, en_out;

  logic             dv_valid;
  logic             dv_ready;
  lane_out_t [1:0]  dv_lane;
  div_side_t        dv_side;

  assign in_box.p = s_axis_tdata[31:0];
  assign in_box.q = s_axis_tdata[63:32];

  irr_trig #(
    .TRIG_STEPS(TRIG_STEPS)
  ) u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .angle_i (s_axis_tdata[79:64]),
    .box_i   (in_box),
    .valid_o (tr_valid),
    .ready_i (tr_ready),
    .cos_o   (tr_cos),
    .sin_o   (tr_sin),
    .box_o   (tr_box)
  );

  assign en_out   = ~out_v_q | m_axis_tready;
  assign en3      = ~s3_v_q | dv_ready;
  assign en2      = ~g2_v_q | en3;
  assign en1      = ~g1_v_q | en2;
  assign tr_ready = en1;

  // k = 2cs
  always_comb begin
    logic [61:0] cs;
    cs      = 62'(tr_cos) * 62'(tr_sin);
    g1_d    = '0;
    g1_d.box = tr_box;
    g1_d.c  = tr_cos;
    g1_d.s  = tr_sin;
    g1_d.k  = cs[60:29];
  end

  always_comb begin
    g2_d    = g1_q;
    g2_d.qk = 64'(g1_q.box.q) * 64'(g1_q.k);
    g2_d.pk = 64'(g1_q.box.p) * 64'(g1_q.k);
  end

  // case decision and divider operands
  always_comb begin
    logic [LEN_W-1:0]  p;
    logic [LEN_W-1:0]  q;
    logic [TRIG_W-1:0] dcs;
    logic [DEN_W-1:0]  csum;
    logic [LEN_W-1:0]  dpq;
    p    = g2_q.box.p;
    q    = g2_q.box.q;
    dcs  = (g2_q.c > g2_q.s) ? g2_q.c - g2_q.s : g2_q.s - g2_q.c;
    csum = DEN_W'(g2_q.c) + DEN_W'(g2_q.s);
    dpq  = (p > q) ? p - q : q - p;

    s3_d.side.lim = (p > q) ? p : q;
    s3_d.side.neg = (p > q) != (g2_q.c > g2_q.s);
    s3_d.ln[0].num = NUM_W'(p) + NUM_W'(q);
    s3_d.ln[0].den = csum;
    s3_d.ln[1].num = NUM_W'(dpq);
    s3_d.ln[1].den = DEN_W'(dcs);

    if (p == '0 || q == '0) begin
      s3_d.side.kase = CASE_EMPTY;
    end else if ({2'b00, p, 30'd0} <= g2_q.qk) begin
      s3_d.side.kase = CASE_WIDTH;
      s3_d.ln[0].num = NUM_W'(p);
      s3_d.ln[0].den = {g2_q.c, 1'b0};
      s3_d.ln[1].num = NUM_W'(p);
      s3_d.ln[1].den = {g2_q.s, 1'b0};
    end else if ({2'b00, q, 30'd0} <= g2_q.pk) begin
      s3_d.side.kase = CASE_HEIGHT;
      s3_d.ln[0].num = NUM_W'(q);
      s3_d.ln[0].den = {g2_q.s, 1'b0};
      s3_d.ln[1].num = NUM_W'(q);
      s3_d.ln[1].den = {g2_q.c, 1'b0};
    end else if (dcs < DIAG_TOL) begin
      s3_d.side.kase = CASE_DIAG;
      s3_d.ln[0].num = NUM_W'((p < q) ? p : q);
    end else begin
      s3_d.side.kase = CASE_BOTH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_v_q  <= 1'b0;
      g2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1)    g1_v_q  <= tr_valid;
      if (en2)    g2_v_q  <= g1_v_q;
      if (en3)    s3_v_q  <= g2_v_q;
      if (en_out) out_v_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1)    g1_q  <= g1_d;
    if (en2)    g2_q  <= g2_d;
    if (en3)    s3_q  <= s3_d;
    if (en_out) out_q <= out_d;
  end

  irr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_v_q),
    .ready_o (dv_ready),
    .lane_i  (s3_q.ln),
    .side_i  (s3_q.side),
    .valid_o (dv_valid),
    .ready_i (en_out),
    .lane_o  (dv_lane),
    .side_o  (dv_side)
  );

  function automatic logic [LEN_W-1:0] bnd(logic [QUO_W:0] val, logic [LEN_W-1:0] lim);
    return (val > (QUO_W+1)'(lim)) ? lim : val[LEN_W-1:0];
  endfunction

  // resolve divider flags, combine and bound
  always_comb begin
    logic [QUO_W:0]        val0;
    logic [QUO_W:0]        val1;
    logic signed [QUO_W+2:0] sdf;
    logic signed [QUO_W+2:0] tu;
    logic signed [QUO_W+2:0] tv;
    logic [LEN_W-1:0]      lim;
    lim  = dv_side.lim;
    val0 = dv_lane[0].dz  ? (QUO_W+1)'(lim) :
           dv_lane[0].ovf ? (QUO_W+1)'(1) << QUO_W : {1'b0, dv_lane[0].quo};
    val1 = dv_lane[1].dz  ? (QUO_W+1)'(lim) :
           dv_lane[1].ovf ? (QUO_W+1)'(1) << QUO_W : {1'b0, dv_lane[1].quo};
    sdf  = dv_side.neg ? -$signed({2'b00, val1}) : $signed({2'b00, val1});
    tu   = $signed({2'b00, val0}) + sdf;
    tv   = $signed({2'b00, val0}) - sdf;

    out_d.kase = dv_side.kase;
    case (dv_side.kase)
      CASE_WIDTH, CASE_HEIGHT: begin
        out_d.u = bnd(val0, lim);
        out_d.v = bnd(val1, lim);
      end
      CASE_DIAG: begin
        out_d.u = bnd(val0, lim);
        out_d.v = bnd(val0, lim);
      end
      CASE_BOTH: begin
        out_d.u = tu[QUO_W+2] ? '0 : bnd(tu[QUO_W+1:1], lim);
        out_d.v = tv[QUO_W+2] ? '0 : bnd(tv[QUO_W+1:1], lim);
      end
      default: begin
        out_d.u = '0;
        out_d.v = '0;
      end
    endcase
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'd0, out_q.kase, out_q.v, out_q.u};

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_q.kase == CASE_EMPTY |-> out_q.u == '0 && out_q.v == '0)
    else $error("empty box gave a nonzero semi-axis");

  a_diag_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_q.kase == CASE_DIAG |-> out_q.u == out_q.v)
    else $error("diagonal case gave unequal semi-axes");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input held off while output is free");

endmodule
